// File: rtl/flst_pkg.sv
package flst_pkg;

  localparam int unsigned SlotW = 7;
  localparam int unsigned DataW = 16;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_ERASE  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ERASE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [DataW-1:0] value;
    logic             sector;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             ok;
    logic [SlotW-1:0] slot;
  } out_t;

endpackage

// File: rtl/flst_mem.sv
module flst_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/flst_ctrl.sv
module flst_ctrl #(
  parameter int unsigned Slots       = 128,
  parameter int unsigned SectorSlots = 64,
  localparam int unsigned AddrW = $clog2(Slots),
  localparam int unsigned CntW  = $clog2(Slots + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  flst_pkg::in_t             in_item_i,
  output logic                      res_valid_o,
  input  logic                      res_ack_i,
  output flst_pkg::out_t            res_o,
  output logic                      mem_we_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [flst_pkg::DataW-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [flst_pkg::DataW-1:0] mem_rdata_i
);

  localparam int unsigned Stop0Int  = (SectorSlots < Slots) ? SectorSlots : Slots;
  localparam int unsigned Stop1Int  = (2 * SectorSlots < Slots) ? 2 * SectorSlots : Slots;
  localparam logic [CntW-1:0]  Start1   = CntW'(Stop0Int);
  localparam logic [CntW-1:0]  Stop0    = CntW'(Stop0Int);
  localparam logic [CntW-1:0]  Stop1    = CntW'(Stop1Int);
  localparam logic [CntW-1:0]  ClearEnd = CntW'(Slots - 1);
  localparam logic [AddrW-1:0] LastIdx  = AddrW'(Slots - 1);

  flst_pkg::state_e  state_q, state_d;
  flst_pkg::action_e act_q, act_d;
  logic [flst_pkg::DataW-1:0] value_q, value_d;
  logic [flst_pkg::DataW-1:0] last_q, last_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   stop_q, stop_d;
  logic [AddrW-1:0]  issue_q, issue_d;
  logic              issue_done_q, issue_done_d;
  logic              chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]  chk_addr_q, chk_addr_d;
  flst_pkg::out_t    res_q, res_d;
  logic              hit, at_end;

  assign hit    = chk_vld_q && (mem_rdata_i == '0);
  assign at_end = chk_vld_q && (chk_addr_q == LastIdx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flst_pkg::ST_CLEAR: begin
        if (cnt_q == ClearEnd) state_d = flst_pkg::ST_IDLE;
      end
      flst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (flst_pkg::action_e'(in_item_i.action)) inside
            flst_pkg::ACT_APPEND, flst_pkg::ACT_READ: state_d = flst_pkg::ST_SCAN;
            flst_pkg::ACT_ERASE: state_d = flst_pkg::ST_ERASE;
            default: state_d = flst_pkg::ST_DONE;
          endcase
        end
      end
      flst_pkg::ST_SCAN: begin
        if (hit || at_end) state_d = flst_pkg::ST_DONE;
      end
      flst_pkg::ST_ERASE: begin
        if (cnt_q >= stop_q) state_d = flst_pkg::ST_DONE;
      end
      flst_pkg::ST_DONE: begin
        if (res_ack_i) state_d = flst_pkg::ST_IDLE;
      end
      default: state_d = flst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act_d        = act_q;
    value_d      = value_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    stop_d       = stop_q;
    issue_d      = issue_q;
    issue_done_d = issue_done_q;
    chk_vld_d    = 1'b0;
    chk_addr_d   = chk_addr_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = issue_q;
    unique case (state_q)
      flst_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[AddrW-1:0];
        cnt_d       = cnt_q + CntW'(1);
      end
      flst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d        = flst_pkg::action_e'(in_item_i.action);
          value_d      = in_item_i.value;
          last_d       = '0;
          issue_d      = '0;
          issue_done_d = 1'b0;
          res_d        = '{data: '0, ok: 1'b1, slot: '0};
          cnt_d        = in_item_i.sector ? Start1 : '0;
          stop_d       = in_item_i.sector ? Stop1 : Stop0;
        end
      end
      flst_pkg::ST_SCAN: begin
        mem_re_o   = !issue_done_q;
        chk_vld_d  = !issue_done_q;
        chk_addr_d = issue_q;
        if (!issue_done_q) begin
          if (issue_q == LastIdx) issue_done_d = 1'b1;
          else issue_d = issue_q + AddrW'(1);
        end
        if (hit) begin
          if (act_q == flst_pkg::ACT_APPEND) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = chk_addr_q;
            mem_wdata_o = value_q;
            res_d.slot  = flst_pkg::SlotW'(chk_addr_q);
          end else if (chk_addr_q != '0) begin
            res_d.data = last_q;
            res_d.slot = flst_pkg::SlotW'(chk_addr_q - AddrW'(1));
          end
        end else if (chk_vld_q) begin
          last_d = mem_rdata_i;
          if (at_end) begin
            if (act_q == flst_pkg::ACT_APPEND) begin
              res_d.ok = 1'b0;
            end else begin
              res_d.data = mem_rdata_i;
              res_d.slot = flst_pkg::SlotW'(LastIdx);
            end
          end
        end
      end
      flst_pkg::ST_ERASE: begin
        if (cnt_q < stop_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + CntW'(1);
        end
      end
      flst_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= flst_pkg::ST_CLEAR;
      cnt_q        <= '0;
      stop_q       <= '0;
      issue_q      <= '0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      act_q        <= flst_pkg::ACT_APPEND;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      stop_q       <= stop_d;
      issue_q      <= issue_d;
      issue_done_q <= issue_done_d;
      chk_vld_q    <= chk_vld_d;
      act_q        <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    last_q     <= last_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
  end

  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flst_pkg::ST_SCAN && mem_we_o) |->
      (act_q == flst_pkg::ACT_APPEND && hit))
    else $error("scan write without empty slot");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (int'(mem_waddr_o) < int'(Slots)))
    else $error("write past end of store");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flst_pkg::ST_CLEAR && cnt_q == ClearEnd) |=> state_q == flst_pkg::ST_IDLE)
    else $error("clear pass did not finish");

  a_erase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flst_pkg::ST_ERASE) |-> (cnt_q <= stop_q))
    else $error("erase counter overran");

  a_done_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flst_pkg::ST_DONE) |-> !mem_we_o)
    else $error("write while result pending");

endmodule

// File: rtl/flash_append_log_store.sv
// channel | valid      | ready      | payload
// in      | in_valid_i  | in_ready_o  | in_item_i  (flst_pkg::in_t)
// out     | out_valid_o | out_ready_i | out_item_o (flst_pkg::out_t)
// After reset a clear pass writes zero to all SLOTS slots; no items are taken meanwhile.
// Append and read_last scan the store one slot per cycle through the single read port.
// Erase writes one slot per cycle over the chosen sector. Unused action codes go straight
// to the result. One item at a time; a result waiting in the output register does not
// block the next item, only the delivery of its result.
module flash_append_log_store #(
  parameter int unsigned SLOTS        = 128,
  parameter int unsigned SECTOR_SLOTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  flst_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output flst_pkg::out_t out_item_o
);

  localparam int unsigned AddrW = $clog2(SLOTS);

  logic                       mem_we, mem_re;
  logic [AddrW-1:0]           mem_waddr, mem_raddr;
  logic [flst_pkg::DataW-1:0] mem_wdata, mem_rdata;
  logic                       res_valid, res_ack;
  flst_pkg::out_t             res;
  logic                       out_valid_q;
  flst_pkg::out_t             out_item_q;

  flst_ctrl #(
    .Slots       (SLOTS),
    .SectorSlots (SECTOR_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ack_i   (res_ack),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  flst_mem #(
    .Depth (SLOTS),
    .Width (flst_pkg::DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
